/* src/assert_macros.svh */
// Assertion macros shared by the tile script lookup RTL.
// Active in simulation; expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TSP_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`define TSP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define TSP_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define TSP_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

/* src/tsp_pkg.sv */
// Types, codes and constants for the tile script priority lookup.
// No dependencies; used by tsp_cell and the top level.
package tsp_pkg;

    localparam logic [7:0] DIR_WILD  = 8'hFF;
    localparam logic [7:0] LANE_F0   = 8'hC0;
    localparam logic [7:0] LANE_F1   = 8'h30;
    localparam logic [7:0] LANE_F2   = 8'h0C;
    localparam logic [7:0] LANE_F3   = 8'h03;
    localparam logic [7:0] LANE_NONE = 8'h00;

    localparam logic [5:0] RESULT_CAP = 6'd32;

    typedef enum logic [1:0] {
        CLS_ANY   = 2'd0,
        CLS_EXACT = 2'd1,
        CLS_WILD  = 2'd2,
        CLS_FALL  = 2'd3
    } t_class;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // table write, broadcast to every cell
    typedef struct packed {
        logic        en;
        logic [4:0]  idx;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [7:0]  dir;
        logic [15:0] code;
    } t_wr;

    // query key, broadcast to every cell
    typedef struct packed {
        logic [3:0] x;
        logic [3:0] y;
        logic [7:0] mask;
        logic [5:0] count;
    } t_query;

    // sequencer control to the cells
    typedef struct packed {
        logic   eval;
        logic   load;
        logic   shift;
        logic   enable;
        t_class cls;
    } t_ctl;

    // one slot of the emission chain
    typedef struct packed {
        logic        pick;
        logic [4:0]  idx;
        logic [7:0]  dir;
        logic [15:0] code;
    } t_slot;

    function automatic logic [7:0] lane_mask(input logic [3:0] facing);
        logic [7:0] m;
        case (facing)
            4'd0:    m = LANE_F0;
            4'd1:    m = LANE_F1;
            4'd2:    m = LANE_F2;
            4'd3:    m = LANE_F3;
            default: m = LANE_NONE;
        endcase
        return m;
    endfunction

endpackage

/* src/tsp_cell.sv */
// One cell of the lookup chain: holds a table entry, its match flags and
// one emission slot that shifts toward cell 0. Depends on tsp_pkg.
module tsp_cell
    import tsp_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_wr    i_wr,
    input  t_query i_query,
    input  t_ctl   i_ctl,
    input  t_slot  i_next,
    output t_slot  o_slot,
    output logic   o_wild,
    output logic   o_exact
);

    logic [3:0]  r_x;
    logic [3:0]  r_y;
    logic [7:0]  r_dir;
    logic [15:0] r_code;
    logic        r_hit;
    logic        r_wild;
    logic        r_exact;
    logic        r_pick;
    logic [4:0]  r_slot_idx;
    logic [7:0]  r_slot_dir;
    logic [15:0] r_slot_code;
    logic        w_match;
    logic        w_sel;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (int'(i_wr.idx) == IDX)) begin
            r_x    <= i_wr.x;
            r_y    <= i_wr.y;
            r_dir  <= i_wr.dir;
            r_code <= i_wr.code;
        end
    end

    assign w_match = (int'(i_query.count) > IDX) && (r_x == i_query.x) && (r_y == i_query.y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit   <= 1'b0;
            r_wild  <= 1'b0;
            r_exact <= 1'b0;
        end else if (i_ctl.eval) begin
            r_hit   <= w_match;
            r_wild  <= w_match && (r_dir == DIR_WILD);
            r_exact <= w_match && (r_dir != DIR_WILD) && (i_query.mask != LANE_NONE)
                       && ((r_dir & i_query.mask) == i_query.mask);
        end
    end

    always_comb begin
        case (i_ctl.cls)
            CLS_EXACT: w_sel = r_exact;
            CLS_WILD:  w_sel = r_wild;
            default:   w_sel = r_hit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pick <= 1'b0;
        end else if (i_ctl.load) begin
            r_pick <= w_sel && i_ctl.enable;
        end else if (i_ctl.shift) begin
            r_pick <= i_next.pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_slot_idx  <= 5'(IDX);
            r_slot_dir  <= r_dir;
            r_slot_code <= r_code;
        end else if (i_ctl.shift) begin
            r_slot_idx  <= i_next.idx;
            r_slot_dir  <= i_next.dir;
            r_slot_code <= i_next.code;
        end
    end

    assign o_slot  = '{pick: r_pick, idx: r_slot_idx, dir: r_slot_dir, code: r_slot_code};
    assign o_wild  = r_wild;
    assign o_exact = r_exact;

endmodule

/* src/tile_script_priority_lookup_core.sv */
// Top level of the tile script priority lookup: stream ports, sequencer,
// output register and the chain of tsp_cell. Depends on tsp_pkg, tsp_cell.
//
// Use: input beats on s_axis; tuser selects a table write (0) or a tile
// query (1). A write loads one entry at the accept edge and gives no result.
// A query returns one or more result beats on m_axis, tlast on the final one;
// a query with no match or a limit of 0 returns a single beat with found = 0.
// entry_count is set through i_cfg_we / i_cfg_wdata, only while the block is idle: a user rule, not enforced.
//
// Timing: a query is latched, all cells compare in parallel (ST_EVAL), the
// priority class is chosen and the emission chain loads (ST_LOAD), then the
// chain shifts toward cell 0 one slot per cycle while its head is not held by
// the output, and the head is emitted when picked. The block is idle again
// once the last result beat is emitted, so how long a query takes is set by
// how far down the chain the last emitted entry sits; writes go back to back.
// s_axis_tready is high only while no query is in progress, so one item is
// worked at a time.
// Reset clears entry_count, the sequencer, chain pick bits and the output
// valid; table contents are undefined until written.
// A stall on m_axis_tready freezes the chain once a picked entry is at its head; the
// output register holds its beat until taken, no result is lost.
module tile_script_priority_lookup_core
    import tsp_pkg::*;
#(
    parameter int MAX_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,     // entry_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [4:0] entry_index, [8:5] tile_x, [12:9] tile_y, [20:13] entry_direction,
    // [36:21] entry_code_offset, [40:37] facing, [46:41] max_out, [47] zero
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tuser,    // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] found, [5:1] match_index, [13:6] match_direction,
    // [29:14] match_code_offset, [31:30] match_class
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_LOAD = 4'b0100,
        ST_SCAN = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [5:0]  r_entry_count;
    logic [3:0]  r_qx, r_qy, r_facing;
    logic [5:0]  r_limit;
    logic [5:0]  r_cnt, n_cnt;
    t_class      r_cls;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_data, n_out_data;
    logic        r_out_last, n_out_last;

    logic        w_in_acc;
    logic [5:0]  w_max_out;
    t_wr         w_wr;
    t_query      w_query;
    t_ctl        w_ctl;
    t_class      w_cls;
    t_slot       w_slot [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0] w_wild, w_exact, w_pick;
    logic        w_any_pick, w_rest_pick, w_out_free, w_last;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_max_out     = s_axis_tdata[46:41];

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    // table write goes straight to the addressed cell
    assign w_wr.en   = w_in_acc && (s_axis_tuser == OP_WRITE);
    assign w_wr.idx  = s_axis_tdata[4:0];
    assign w_wr.x    = s_axis_tdata[8:5];
    assign w_wr.y    = s_axis_tdata[12:9];
    assign w_wr.dir  = s_axis_tdata[20:13];
    assign w_wr.code = s_axis_tdata[36:21];

    // query key, limit saturated to the result cap
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (s_axis_tuser == OP_QUERY)) begin
            r_qx     <= s_axis_tdata[8:5];
            r_qy     <= s_axis_tdata[12:9];
            r_facing <= s_axis_tdata[40:37];
            r_limit  <= (w_max_out > RESULT_CAP) ? RESULT_CAP : w_max_out;
        end
    end

    assign w_query.x     = r_qx;
    assign w_query.y     = r_qy;
    assign w_query.mask  = lane_mask(r_facing);
    assign w_query.count = r_entry_count;

    // priority class: negative facing takes all, then exact, wildcard, fallback
    always_comb begin
        if (r_facing[3])       w_cls = CLS_ANY;
        else if (|w_exact)     w_cls = CLS_EXACT;
        else if (|w_wild)      w_cls = CLS_WILD;
        else                   w_cls = CLS_FALL;
    end

    // chain head and pick summary
    assign w_slot[MAX_ENTRIES] = '0;
    assign w_any_pick  = |w_pick;
    assign w_rest_pick = |(w_pick >> 1);
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_last      = ((r_cnt + 6'd1) == r_limit) || !w_rest_pick;

    assign w_ctl.eval   = (r_state == ST_EVAL);
    assign w_ctl.load   = (r_state == ST_LOAD);
    assign w_ctl.enable = (r_limit != 6'd0);
    assign w_ctl.cls    = w_cls;
    assign w_ctl.shift  = (r_state == ST_SCAN) && (!w_slot[0].pick || w_out_free);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
            tsp_cell #(
                .IDX(gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_wr    (w_wr),
                .i_query (w_query),
                .i_ctl   (w_ctl),
                .i_next  (w_slot[gi+1]),
                .o_slot  (w_slot[gi]),
                .o_wild  (w_wild[gi]),
                .o_exact (w_exact[gi])
            );
            assign w_pick[gi] = w_slot[gi].pick;
        end
    endgenerate

    // sequencer and output register
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (s_axis_tuser == OP_QUERY)) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_cnt   = '0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (!w_any_pick) begin
                    // nothing found (or limit 0): single empty beat
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                        n_out_last  = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end else if (w_slot[0].pick && w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_cls, w_slot[0].code, w_slot[0].dir, w_slot[0].idx, 1'b1};
                    n_out_last  = w_last;
                    n_cnt       = r_cnt + 6'd1;
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        if (r_state == ST_LOAD) begin
            r_cls <= w_cls;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // emitted count never passes the limit while scanning
    `TSP_ASSERT_IMPLY(a_cnt_limit, i_clk, i_rst_n, r_state == ST_SCAN, r_cnt <= r_limit)
    // an exhausted chain mid-scan means nothing was emitted yet (last closes a run)
    `TSP_ASSERT_IMPLY(a_empty_scan, i_clk, i_rst_n, (r_state == ST_SCAN) && !w_any_pick,
                      r_cnt == 6'd0)
    // an empty beat is always the final beat of its query
    `TSP_ASSERT_IMPLY(a_empty_last, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[0],
                      m_axis_tlast)
    // a query always goes through the compare cycle
    `TSP_ASSERT_NEXT(a_query_eval, i_clk, i_rst_n,
                     w_in_acc && (s_axis_tuser == OP_QUERY), r_state == ST_EVAL)

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for tile_script_priority_lookup_core: table writes and
// tile queries on the input stream, result beats checked against a local predictor.
// Depends on tsp_pkg and the RTL of the core only.
module testbench
    import tsp_pkg::*;
();

    localparam int MAX_ENTRIES  = 32;
    localparam int DRAIN_CYCLES = MAX_ENTRIES + 8;   // longest query plus slack
    localparam int HOLD_CYCLES  = 400;               // long output hold-off
    localparam int CYCLE_LIMIT  = 500000;

    // one expected result beat
    typedef struct packed {
        logic        found;
        logic [4:0]  idx;
        logic [7:0]  dir;
        logic [15:0] code;
        t_class      cls;
        logic        last;
    } t_lookup_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [5:0]  i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    // shadow copy of the lookup table and of entry_count
    logic [3:0]  table_x    [MAX_ENTRIES];
    logic [3:0]  table_y    [MAX_ENTRIES];
    logic [7:0]  table_dir  [MAX_ENTRIES];
    logic [15:0] table_code [MAX_ENTRIES];
    logic [5:0]  active_entries = '0;

    t_lookup_result pending_matches [$];

    int fail_count     = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_token     = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    tile_script_priority_lookup_core #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Output side: random stalls, or a long hold-off when the test bumps
    // hold_token. The hold is counted here so the sender keeps pushing.
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen     <= hold_token;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Each accepted result beat against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_lookup_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_matches.size() == 0) begin
                $error("result beat with nothing expected: tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_matches.pop_front();
                check_field("found", 16'(want.found), 16'(m_axis_tdata[0]));
                check_field("match_index", 16'(want.idx), 16'(m_axis_tdata[5:1]));
                check_field("match_direction", 16'(want.dir), 16'(m_axis_tdata[13:6]));
                check_field("match_code_offset", want.code, m_axis_tdata[29:14]);
                check_field("match_class", 16'(want.cls), 16'(m_axis_tdata[31:30]));
                check_field("last", 16'(want.last), 16'(m_axis_tlast));
            end
        end
    end

    // Expected beats of one query against the shadow table.
    task automatic predict_lookup(input logic [3:0] qx, input logic [3:0] qy,
                                  input logic [3:0] fac, input logic [5:0] lim);
        t_lookup_result res [MAX_ENTRIES];
        bit             hit [MAX_ENTRIES];
        logic [7:0]     mask;
        int             n, cap, cnt, n_all, n_exact, n_wild;
        t_class         cls;
        bit             take;
        n       = (active_entries > MAX_ENTRIES) ? MAX_ENTRIES : active_entries;
        cap     = (lim > RESULT_CAP) ? int'(RESULT_CAP) : int'(lim);
        cnt     = 0;
        n_all   = 0;
        n_exact = 0;
        n_wild  = 0;
        cls     = CLS_ANY;
        case (fac)
            4'd0:    mask = LANE_F0;
            4'd1:    mask = LANE_F1;
            4'd2:    mask = LANE_F2;
            4'd3:    mask = LANE_F3;
            default: mask = LANE_NONE;   // negative or 4..7
        endcase
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            hit[i] = (i < n) && table_x[i] == qx && table_y[i] == qy;
            if (hit[i]) begin
                n_all++;
                if (table_dir[i] == DIR_WILD)
                    n_wild++;
                else if (mask != LANE_NONE && (table_dir[i] & mask) == mask)
                    n_exact++;
            end
        end
        if (n_all != 0 && cap != 0) begin
            // priority: any facing, exact lane, wildcard, then everything
            if (fac[3])
                cls = CLS_ANY;
            else if (n_exact > 0)
                cls = CLS_EXACT;
            else if (n_wild > 0)
                cls = CLS_WILD;
            else
                cls = CLS_FALL;
            for (int i = 0; i < MAX_ENTRIES && cnt < cap; i++) begin
                case (cls)
                    CLS_EXACT: take = hit[i] && table_dir[i] != DIR_WILD &&
                                      (table_dir[i] & mask) == mask;
                    CLS_WILD:  take = hit[i] && table_dir[i] == DIR_WILD;
                    default:   take = hit[i];
                endcase
                if (take) begin
                    res[cnt] = '{found: 1'b1, idx: 5'(i), dir: table_dir[i],
                                 code: table_code[i], cls: cls, last: 1'b0};
                    cnt++;
                end
            end
        end
        if (cnt == 0) begin
            pending_matches.push_back('{found: 1'b0, idx: 5'd0, dir: 8'd0, code: 16'd0,
                                        cls: CLS_ANY, last: 1'b1});
        end else begin
            res[cnt-1].last = 1'b1;
            for (int i = 0; i < cnt; i++)
                pending_matches.push_back(res[i]);
        end
    endtask

    // Offer one beat, wait for the accept edge, then update the predictor.
    // Called right after a rising edge; returns in the accept step.
    task automatic send_beat(input t_op op, input logic [4:0] idx,
                             input logic [3:0] x, input logic [3:0] y,
                             input logic [7:0] dir, input logic [15:0] code,
                             input logic [3:0] facing, input logic [5:0] lim);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, lim, facing, code, dir, y, x, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == OP_WRITE) begin
            table_x[idx]    = x;
            table_y[idx]    = y;
            table_dir[idx]  = dir;
            table_code[idx] = code;
        end else begin
            predict_lookup(x, y, facing, lim);
        end
    endtask

    // Input quiet, every expected beat in, then the block's own latency.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_entry_count(input logic [5:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        active_entries  = value;
    endtask

    // mostly a handful of tiles so queries hit several entries
    function automatic logic [3:0] rand_coord();
        return ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] rand_dir();
        logic [7:0] lanes [4] = '{LANE_F0, LANE_F1, LANE_F2, LANE_F3};
        case ($urandom_range(0, 3))
            0:       return DIR_WILD;
            1:       return 8'($urandom);
            default: return 8'($urandom) | lanes[$urandom_range(0, 3)];
        endcase
    endfunction

    function automatic logic [3:0] rand_facing();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 4'($urandom_range(0, 3));
        else if (r == 6)
            return 4'hF;                          // -1
        else if (r == 7)
            return 4'($urandom_range(8, 15));     // other negatives
        else
            return 4'($urandom_range(4, 7));      // empty lane mask
    endfunction

    function automatic logic [5:0] rand_limit();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 6'd0;
        else if (r == 1)
            return 6'($urandom_range(33, 63));    // saturates
        else
            return 6'($urandom_range(1, 32));
    endfunction

    // Hand-built table in slots 0..7 and a query for each priority path.
    task automatic test_directed_lookup();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_entry_count(6'd0);
        // empty table view: nothing examined, so not found
        send_beat(OP_QUERY, 5'd31, 4'd2, 4'd3, 8'hFF, 16'hFFFF, 4'hF, 6'd32);
        send_beat(OP_WRITE, 5'd0, 4'd2,  4'd3,  8'hC0,    16'h0000, 4'hF, 6'h3F);
        send_beat(OP_WRITE, 5'd1, 4'd2,  4'd3,  DIR_WILD, 16'hFFFF, 4'h0, 6'h00);
        send_beat(OP_WRITE, 5'd2, 4'd2,  4'd3,  8'h33,    16'h1234, 4'h8, 6'h2A);
        send_beat(OP_WRITE, 5'd3, 4'd15, 4'd15, 8'h00,    16'hABCD, 4'h7, 6'h15);
        send_beat(OP_WRITE, 5'd4, 4'd15, 4'd15, 8'h80,    16'h8001, 4'h1, 6'h01);
        send_beat(OP_WRITE, 5'd5, 4'd0,  4'd0,  DIR_WILD, 16'h5A5A, 4'h2, 6'h20);
        send_beat(OP_WRITE, 5'd6, 4'd2,  4'd3,  8'h0C,    16'h00FF, 4'h3, 6'h10);
        send_beat(OP_WRITE, 5'd7, 4'd0,  4'd0,  8'h3C,    16'hC3C3, 4'h4, 6'h08);
        set_entry_count(6'd8);
        send_beat(OP_QUERY, 5'd0, 4'd2,  4'd3,  8'h00, 16'h0000, 4'hF, 6'd32);  // any, -1
        send_beat(OP_QUERY, 5'd0, 4'd2,  4'd3,  8'h00, 16'h0000, 4'h8, 6'd63);  // -8, big limit
        send_beat(OP_QUERY, 5'd0, 4'd2,  4'd3,  8'h00, 16'h0000, 4'd0, 6'd32);  // exact lanes
        send_beat(OP_QUERY, 5'd0, 4'd2,  4'd3,  8'h00, 16'h0000, 4'd1, 6'd32);
        send_beat(OP_QUERY, 5'd0, 4'd2,  4'd3,  8'h00, 16'h0000, 4'd2, 6'd32);
        send_beat(OP_QUERY, 5'd0, 4'd2,  4'd3,  8'h00, 16'h0000, 4'd3, 6'd32);
        send_beat(OP_QUERY, 5'd0, 4'd2,  4'd3,  8'h00, 16'h0000, 4'd4, 6'd32);  // wildcard
        send_beat(OP_QUERY, 5'd0, 4'd15, 4'd15, 8'h00, 16'h0000, 4'd0, 6'd32);  // fallback
        send_beat(OP_QUERY, 5'd0, 4'd15, 4'd15, 8'h00, 16'h0000, 4'd7, 6'd32);
        send_beat(OP_QUERY, 5'd0, 4'd0,  4'd0,  8'h00, 16'h0000, 4'd2, 6'd32);
        send_beat(OP_QUERY, 5'd0, 4'd0,  4'd0,  8'h00, 16'h0000, 4'd3, 6'd32);
        send_beat(OP_QUERY, 5'd0, 4'd2,  4'd3,  8'h00, 16'h0000, 4'hF, 6'd0);   // limit 0
        send_beat(OP_QUERY, 5'd0, 4'd2,  4'd3,  8'h00, 16'h0000, 4'hF, 6'd1);   // cut to one
        send_beat(OP_QUERY, 5'd0, 4'd9,  4'd9,  8'h00, 16'h0000, 4'hF, 6'd32);  // no match
    endtask

    // Load the rest of the table so any entry_count is legal from here on.
    task automatic test_table_fill();
        for (int slot = 8; slot < MAX_ENTRIES; slot++)
            send_beat(OP_WRITE, 5'(slot), rand_coord(), rand_coord(), rand_dir(),
                      16'($urandom), 4'($urandom), 6'($urandom));
    endtask

    // Mixed writes and queries under one idle profile and one entry_count.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic [5:0] count_setting, input int items);
        set_entry_count(count_setting);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (items) begin
            if ($urandom_range(0, 9) < 3)
                send_beat(OP_WRITE, 5'($urandom), rand_coord(), rand_coord(), rand_dir(),
                          16'($urandom), 4'($urandom), 6'($urandom));
            else
                send_beat(OP_QUERY, 5'($urandom), rand_coord(), rand_coord(),
                          8'($urandom), 16'($urandom), rand_facing(), rand_limit());
        end
    endtask

    // Long output hold-off while queries with many beats keep arriving:
    // the core must stall its input and lose nothing.
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_entry_count(6'd32);
        for (int k = 0; k < 12; k++)
            send_beat(OP_WRITE, 5'(k), 4'd5, 4'd5, (k % 3 == 0) ? 8'h5A : DIR_WILD,
                      16'($urandom), 4'h0, 6'h00);
        hold_token++;
        for (int k = 0; k < 6; k++)
            send_beat(OP_QUERY, 5'($urandom), 4'd5, 4'd5, 8'($urandom), 16'($urandom),
                      (k % 2 == 1) ? 4'hF : 4'd4, 6'd32);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_lookup();
        test_table_fill();
        test_random_traffic(0, 0, 6'd32, 50);                           // no idling
        test_random_traffic(60, 0, 6'd63, 50);                          // count saturates
        test_random_traffic(0, 60, 6'($urandom_range(1, 31)), 50);
        test_random_traffic(7, 7, 6'($urandom_range(0, 63)), 50);
        test_output_backpressure();
        wait_drained();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
